[rtl/rrm_pkg.sv]
`timescale 1ns / 1ps
// shared constants, lane types and fixed-point helpers for the rotation matrix block
// no dependencies

package rrm_pkg;

    localparam int INPUT_FRACTION_BITS  = 16;
    localparam int OUTPUT_FRACTION_BITS = 14;
    localparam int OUT_W       = OUTPUT_FRACTION_BITS + 2;
    localparam int QB          = 30;
    localparam int OUT_SHIFT   = QB - OUTPUT_FRACTION_BITS;
    localparam longint OUT_HALF = (OUT_SHIFT > 0) ? (longint'(1) << (OUT_SHIFT - 1)) : 0;
    localparam logic signed [34:0] OUT_ONE = 35'(longint'(1) << OUTPUT_FRACTION_BITS);

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] Q_ONE       = 31'd1 << QB;

    localparam int TERM_CELLS  = 8;
    localparam int RECIP_SHIFT = 33;
    localparam int SQRT_STEPS  = 32;
    localparam int ANGLE_LAT   = 2 + 3 * TERM_CELLS + 2;
    localparam int QUAD_DEPTH  = ANGLE_LAT - 1;
    localparam int ALIGN_DEPTH = SQRT_STEPS - ANGLE_LAT;
    localparam int POST_STAGES = 5;
    localparam int PIPE_DEPTH  = SQRT_STEPS + POST_STAGES + 1;
    localparam int P_DEPTH     = PIPE_DEPTH - 2;

    localparam logic [8:0] SIN_DIV [TERM_CELLS] = '{
        9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272};
    localparam logic [8:0] COS_DIV [TERM_CELLS] = '{
        9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240};

    localparam logic [32:0] SIN_RECIP [TERM_CELLS] = '{
        33'((64'd1 << RECIP_SHIFT) / 64'd6),   33'((64'd1 << RECIP_SHIFT) / 64'd20),
        33'((64'd1 << RECIP_SHIFT) / 64'd42),  33'((64'd1 << RECIP_SHIFT) / 64'd72),
        33'((64'd1 << RECIP_SHIFT) / 64'd110), 33'((64'd1 << RECIP_SHIFT) / 64'd156),
        33'((64'd1 << RECIP_SHIFT) / 64'd210), 33'((64'd1 << RECIP_SHIFT) / 64'd272)};
    localparam logic [32:0] COS_RECIP [TERM_CELLS] = '{
        33'((64'd1 << RECIP_SHIFT) / 64'd2),   33'((64'd1 << RECIP_SHIFT) / 64'd12),
        33'((64'd1 << RECIP_SHIFT) / 64'd30),  33'((64'd1 << RECIP_SHIFT) / 64'd56),
        33'((64'd1 << RECIP_SHIFT) / 64'd90),  33'((64'd1 << RECIP_SHIFT) / 64'd132),
        33'((64'd1 << RECIP_SHIFT) / 64'd182), 33'((64'd1 << RECIP_SHIFT) / 64'd240)};

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quadrant_t;

    typedef struct packed {
        logic [30:0]        term;
        logic signed [33:0] sum;
        logic [31:0]        x2;
    } series_lane_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
    } sqrt_lane_t;

    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] c;
    } trig_t;

    // q30 product, floor toward minus infinity
    function automatic logic signed [32:0] qmul(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b);
        return 33'(p >>> QB);
    endfunction

    // round, floor-shift and saturate to plus or minus one
    function automatic logic [OUT_W-1:0] to_out(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [34:0] r;
        t = 35'(v) + 35'(OUT_HALF);
        r = t >>> OUT_SHIFT;
        if (r > OUT_ONE)
        begin
            r = OUT_ONE;
        end
        else if (r < -OUT_ONE)
        begin
            r = -OUT_ONE;
        end
        return OUT_W'(r);
    endfunction

endpackage

[rtl/rrm_series_cell.sv]
`timescale 1ns / 1ps
// one taylor term cell: adds the current term, then forms the next term over three stages
// depends on rrm_pkg

module rrm_series_cell
    import rrm_pkg::*;
(
    input  logic         clk,
    input  logic         en,
    input  series_lane_t lane_in,
    input  logic [8:0]   div,
    input  logic [32:0]  recip,
    input  logic         sub,
    output series_lane_t lane_out
);

    logic signed [33:0] s1_sum_reg, s1_sum_next;
    logic [62:0]        s1_prod_reg, s1_prod_next;
    logic [31:0]        s1_x2_reg;

    logic signed [33:0] s2_sum_reg;
    logic [31:0]        s2_x2_reg;
    logic [32:0]        s2_n_reg, s2_n_next;
    logic [32:0]        s2_q_reg, s2_q_next;
    logic [65:0]        s2_p;

    logic [41:0]        s3_qd;
    logic [41:0]        s3_rem;
    series_lane_t       out_reg, out_next;

    always_comb
    begin
        if (sub)
        begin
            s1_sum_next = lane_in.sum - $signed({3'b000, lane_in.term});
        end
        else
        begin
            s1_sum_next = lane_in.sum + $signed({3'b000, lane_in.term});
        end
        s1_prod_next = 63'(lane_in.term) * 63'(lane_in.x2);
    end

    // reciprocal estimate, low by at most one
    always_comb
    begin
        s2_n_next = s1_prod_reg[62:30];
        s2_p      = 66'(s2_n_next) * 66'(recip);
        s2_q_next = s2_p[65:33];
    end

    always_comb
    begin
        s3_qd  = 42'(s2_q_reg) * 42'(div);
        s3_rem = 42'(s2_n_reg) - s3_qd;
        out_next.sum = s2_sum_reg;
        out_next.x2  = s2_x2_reg;
        if (s3_rem >= 42'(div))
        begin
            out_next.term = 31'(s2_q_reg + 33'd1);
        end
        else
        begin
            out_next.term = 31'(s2_q_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sum_reg  <= s1_sum_next;
            s1_prod_reg <= s1_prod_next;
            s1_x2_reg   <= lane_in.x2;
            s2_sum_reg  <= s1_sum_reg;
            s2_x2_reg   <= s1_x2_reg;
            s2_n_reg    <= s2_n_next;
            s2_q_reg    <= s2_q_next;
            out_reg     <= out_next;
        end
    end

    assign lane_out = out_reg;

endmodule

[rtl/rrm_sqrt_cell.sv]
`timescale 1ns / 1ps
// one bit step of the integer square root chain
// depends on rrm_pkg

module rrm_sqrt_cell
    import rrm_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  sqrt_lane_t  lane_in,
    input  logic [63:0] bitval,
    output sqrt_lane_t  lane_out
);

    logic [63:0] trial;
    sqrt_lane_t  out_reg, out_next;

    always_comb
    begin
        trial = lane_in.root + bitval;
        if (lane_in.rem >= trial)
        begin
            out_next.rem  = lane_in.rem - trial;
            out_next.root = (lane_in.root >> 1) + bitval;
        end
        else
        begin
            out_next.rem  = lane_in.rem;
            out_next.root = lane_in.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign lane_out = out_reg;

endmodule

[rtl/rrm_angle.sv]
`timescale 1ns / 1ps
// sine and cosine of a turn fraction: angle scaling, two chains of series cells, quadrant fold
// depends on rrm_pkg and rrm_series_cell

module rrm_angle
    import rrm_pkg::*;
(
    input  logic                           clk,
    input  logic                           en,
    input  logic [INPUT_FRACTION_BITS-1:0] frac,
    output trig_t                          trig
);

    logic [31:0]  turn;
    logic [60:0]  x_prod;
    logic [61:0]  x2_prod;
    logic [30:0]  x_reg;
    logic [30:0]  x_d_reg;
    logic [31:0]  x2_reg;
    logic [1:0]   quad_reg [QUAD_DEPTH];

    series_lane_t sin_lane [TERM_CELLS+1];
    series_lane_t cos_lane [TERM_CELLS+1];

    logic signed [33:0] sin_sum, cos_sum;
    logic [30:0]        sin_clamp, cos_clamp;
    logic [30:0]        s0_reg, c0_reg;
    logic signed [31:0] s0_pos, c0_pos;
    trig_t              trig_reg, trig_next;
    quadrant_t          quad;

    assign turn    = 32'(frac) << (32 - INPUT_FRACTION_BITS);
    assign x_prod  = 61'(turn[29:0]) * 61'(HALF_PI_Q30);
    assign x2_prod = 62'(x_reg) * 62'(x_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg       <= x_prod[60:30];
            x_d_reg     <= x_reg;
            x2_reg      <= x2_prod[61:30];
            quad_reg[0] <= turn[31:30];
            for (int i = 1; i < QUAD_DEPTH; i++)
            begin
                quad_reg[i] <= quad_reg[i-1];
            end
        end
    end

    assign sin_lane[0] = '{term: x_d_reg, sum: 34'sd0, x2: x2_reg};
    assign cos_lane[0] = '{term: Q_ONE, sum: 34'sd0, x2: x2_reg};

    for (genvar j = 0; j < TERM_CELLS; j++)
    begin : g_cells
        rrm_series_cell u_sin_cell (
            .clk      (clk),
            .en       (en),
            .lane_in  (sin_lane[j]),
            .div      (SIN_DIV[j]),
            .recip    (SIN_RECIP[j]),
            .sub      (1'(j & 1)),
            .lane_out (sin_lane[j+1])
        );
        rrm_series_cell u_cos_cell (
            .clk      (clk),
            .en       (en),
            .lane_in  (cos_lane[j]),
            .div      (COS_DIV[j]),
            .recip    (COS_RECIP[j]),
            .sub      (1'(j & 1)),
            .lane_out (cos_lane[j+1])
        );
    end

    // last term and clamp to [0, one]
    always_comb
    begin
        sin_sum = sin_lane[TERM_CELLS].sum + $signed({3'b000, sin_lane[TERM_CELLS].term});
        cos_sum = cos_lane[TERM_CELLS].sum + $signed({3'b000, cos_lane[TERM_CELLS].term});
        if (sin_sum < 0)
        begin
            sin_clamp = '0;
        end
        else if (sin_sum > $signed(34'(Q_ONE)))
        begin
            sin_clamp = Q_ONE;
        end
        else
        begin
            sin_clamp = 31'(sin_sum);
        end
        if (cos_sum < 0)
        begin
            cos_clamp = '0;
        end
        else if (cos_sum > $signed(34'(Q_ONE)))
        begin
            cos_clamp = Q_ONE;
        end
        else
        begin
            cos_clamp = 31'(cos_sum);
        end
    end

    assign s0_pos = $signed({1'b0, s0_reg});
    assign c0_pos = $signed({1'b0, c0_reg});
    assign quad   = quadrant_t'(quad_reg[QUAD_DEPTH-1]);

    always_comb
    begin
        case (quad)
            QUAD_0:
            begin
                trig_next.s = s0_pos;
                trig_next.c = c0_pos;
            end
            QUAD_1:
            begin
                trig_next.s = c0_pos;
                trig_next.c = -s0_pos;
            end
            QUAD_2:
            begin
                trig_next.s = -s0_pos;
                trig_next.c = -c0_pos;
            end
            default:
            begin
                trig_next.s = -c0_pos;
                trig_next.c = s0_pos;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg   <= sin_clamp;
            c0_reg   <= cos_clamp;
            trig_reg <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule

[rtl/random_rotation_matrix.sv]
`timescale 1ns / 1ps
// random rotation matrix top level: input register, angle units, root chains, matrix products
// depends on rrm_pkg, rrm_angle, rrm_sqrt_cell
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------------------
//   item     | item_valid / item_ready    | theta_fraction, phi_fraction, pole_fraction
//   result   | result_valid / result_ready| row0_col0 .. row2_col2
//
// one item per cycle while the output is not stalled; each item passes through
// the input register, the 32-step square root chain and five product stages
// reset clears only the stage valid bits
// a result held at the output stalls the whole pipeline; item_ready then drops

module random_rotation_matrix
    import rrm_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  logic [INPUT_FRACTION_BITS-1:0] theta_fraction,
    input  logic [INPUT_FRACTION_BITS-1:0] phi_fraction,
    input  logic [INPUT_FRACTION_BITS-1:0] pole_fraction,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic signed [OUT_W-1:0]        row0_col0,
    output logic signed [OUT_W-1:0]        row0_col1,
    output logic signed [OUT_W-1:0]        row0_col2,
    output logic signed [OUT_W-1:0]        row1_col0,
    output logic signed [OUT_W-1:0]        row1_col1,
    output logic signed [OUT_W-1:0]        row1_col2,
    output logic signed [OUT_W-1:0]        row2_col0,
    output logic signed [OUT_W-1:0]        row2_col1,
    output logic signed [OUT_W-1:0]        row2_col2
);

    logic en;
    logic vld_reg [PIPE_DEPTH];

    logic [INPUT_FRACTION_BITS-1:0] theta_reg, phi_reg, pole_reg;
    logic [INPUT_FRACTION_BITS-1:0] pole_pipe_reg [P_DEPTH];

    trig_t theta_trig, phi_trig;
    trig_t theta_d_reg [ALIGN_DEPTH];
    trig_t phi_d_reg [ALIGN_DEPTH];

    logic [31:0] z0;
    logic [31:0] z_end;
    sqrt_lane_t  r_lane [SQRT_STEPS+1];
    sqrt_lane_t  w_lane [SQRT_STEPS+1];

    logic signed [32:0] sp, cp, st, ct, rr, vz;
    logic signed [32:0] vx_reg, vy_reg, vz33_reg, st33_reg, ct33_reg;
    logic signed [32:0] xc_reg, ys_reg, xs_reg, yc_reg;
    logic signed [32:0] vx34_reg, vy34_reg, vz34_reg, st34_reg, ct34_reg;
    logic signed [32:0] sx_reg, sy_reg, vx35_reg, vy35_reg, vz35_reg, st35_reg, ct35_reg;
    logic signed [32:0] e_reg [8];
    logic signed [32:0] st36_reg, ct36_reg;
    logic signed [33:0] one_minus_z;
    logic [OUT_W-1:0]   m_reg [9];

    assign en         = !vld_reg[PIPE_DEPTH-1] || result_ready;
    assign item_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= item_valid;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            theta_reg        <= theta_fraction;
            phi_reg          <= phi_fraction;
            pole_reg         <= pole_fraction;
            pole_pipe_reg[0] <= pole_reg;
            for (int i = 1; i < P_DEPTH; i++)
            begin
                pole_pipe_reg[i] <= pole_pipe_reg[i-1];
            end
            theta_d_reg[0] <= theta_trig;
            phi_d_reg[0]   <= phi_trig;
            for (int i = 1; i < ALIGN_DEPTH; i++)
            begin
                theta_d_reg[i] <= theta_d_reg[i-1];
                phi_d_reg[i]   <= phi_d_reg[i-1];
            end
        end
    end

    rrm_angle u_theta (
        .clk  (clk),
        .en   (en),
        .frac (theta_reg),
        .trig (theta_trig)
    );

    rrm_angle u_phi (
        .clk  (clk),
        .en   (en),
        .frac (phi_reg),
        .trig (phi_trig)
    );

    // sqrt(z) and sqrt(2 - z) in q30
    assign z0 = 32'(pole_reg) << (31 - INPUT_FRACTION_BITS);
    assign r_lane[0] = '{rem: 64'(z0) << QB, root: 64'd0};
    assign w_lane[0] = '{rem: (64'(33'h1_0000_0000 >> 1) - 64'(z0)) << QB, root: 64'd0};

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        localparam logic [63:0] BITVAL = 64'd1 << (2 * SQRT_STEPS - 2 - 2 * i);
        rrm_sqrt_cell u_r_cell (
            .clk      (clk),
            .en       (en),
            .lane_in  (r_lane[i]),
            .bitval   (BITVAL),
            .lane_out (r_lane[i+1])
        );
        rrm_sqrt_cell u_w_cell (
            .clk      (clk),
            .en       (en),
            .lane_in  (w_lane[i]),
            .bitval   (BITVAL),
            .lane_out (w_lane[i+1])
        );
    end

    assign sp = 33'(phi_d_reg[ALIGN_DEPTH-1].s);
    assign cp = 33'(phi_d_reg[ALIGN_DEPTH-1].c);
    assign st = 33'(theta_d_reg[ALIGN_DEPTH-1].s);
    assign ct = 33'(theta_d_reg[ALIGN_DEPTH-1].c);
    assign rr = $signed({1'b0, r_lane[SQRT_STEPS].root[31:0]});
    assign vz = $signed({1'b0, w_lane[SQRT_STEPS].root[31:0]});

    assign z_end       = 32'(pole_pipe_reg[P_DEPTH-1]) << (31 - INPUT_FRACTION_BITS);
    assign one_minus_z = $signed(34'(Q_ONE)) - $signed(34'(z_end));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg   <= qmul(sp, rr);
            vy_reg   <= qmul(cp, rr);
            vz33_reg <= vz;
            st33_reg <= st;
            ct33_reg <= ct;

            xc_reg   <= qmul(vx_reg, ct33_reg);
            ys_reg   <= qmul(vy_reg, st33_reg);
            xs_reg   <= qmul(vx_reg, st33_reg);
            yc_reg   <= qmul(vy_reg, ct33_reg);
            vx34_reg <= vx_reg;
            vy34_reg <= vy_reg;
            vz34_reg <= vz33_reg;
            st34_reg <= st33_reg;
            ct34_reg <= ct33_reg;

            sx_reg   <= xc_reg - ys_reg;
            sy_reg   <= xs_reg + yc_reg;
            vx35_reg <= vx34_reg;
            vy35_reg <= vy34_reg;
            vz35_reg <= vz34_reg;
            st35_reg <= st34_reg;
            ct35_reg <= ct34_reg;

            e_reg[0] <= qmul(vx35_reg, sx_reg);
            e_reg[1] <= qmul(vx35_reg, sy_reg);
            e_reg[2] <= qmul(vx35_reg, vz35_reg);
            e_reg[3] <= qmul(vy35_reg, sx_reg);
            e_reg[4] <= qmul(vy35_reg, sy_reg);
            e_reg[5] <= qmul(vy35_reg, vz35_reg);
            e_reg[6] <= qmul(vz35_reg, sx_reg);
            e_reg[7] <= qmul(vz35_reg, sy_reg);
            st36_reg <= st35_reg;
            ct36_reg <= ct35_reg;

            m_reg[0] <= to_out(34'(e_reg[0]) - 34'(ct36_reg));
            m_reg[1] <= to_out(34'(e_reg[1]) - 34'(st36_reg));
            m_reg[2] <= to_out(34'(e_reg[2]));
            m_reg[3] <= to_out(34'(e_reg[3]) + 34'(st36_reg));
            m_reg[4] <= to_out(34'(e_reg[4]) - 34'(ct36_reg));
            m_reg[5] <= to_out(34'(e_reg[5]));
            m_reg[6] <= to_out(34'(e_reg[6]));
            m_reg[7] <= to_out(34'(e_reg[7]));
            m_reg[8] <= to_out(one_minus_z);
        end
    end

    assign result_valid = vld_reg[PIPE_DEPTH-1];
    assign row0_col0    = $signed(m_reg[0]);
    assign row0_col1    = $signed(m_reg[1]);
    assign row0_col2    = $signed(m_reg[2]);
    assign row1_col0    = $signed(m_reg[3]);
    assign row1_col1    = $signed(m_reg[4]);
    assign row1_col2    = $signed(m_reg[5]);
    assign row2_col0    = $signed(m_reg[6]);
    assign row2_col1    = $signed(m_reg[7]);
    assign row2_col2    = $signed(m_reg[8]);

endmodule
